// ===== design/ows_pkg.sv =====
package ows_pkg;

	// Input beat kinds
	typedef enum logic [1:0] {
		KIND_RESTART   = 2'd0,
		KIND_BUS_RESET = 2'd1,
		KIND_BIT_PAIR  = 2'd2
	} kind_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_BIT_CHOSEN   = 3'd0,
		ST_FOUND        = 3'd1,
		ST_CRC_ERROR    = 3'd2,
		ST_NO_RESPONSE  = 3'd3,
		ST_NO_PRESENCE  = 3'd4,
		ST_DONE         = 3'd5,
		ST_PASS_STARTED = 3'd6,
		ST_IGNORED      = 3'd7
	} status_t;

	localparam int unsigned ROM_BITS = 64;
	localparam int unsigned POS_W    = 7;

	localparam logic [7:0]       CRC_POLY     = 8'h8C;
	localparam logic [POS_W-1:0] END_POSITION = 7'd65;
	localparam logic [POS_W-1:0] CRC_BITS     = 7'd56;
	localparam logic [POS_W-1:0] LAST_BIT     = 7'd64;
	localparam logic [POS_W-1:0] FIRST_BIT    = 7'd1;

endpackage

// ===== design/ows_if.sv =====
// Request channel: one beat per restart, bus reset result or bit pair
interface ows_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic       presence;
	logic       id_bit;
	logic       complement_bit;

	modport source (output valid, kind, presence, id_bit, complement_bit, input ready);
	modport sink   (input valid, kind, presence, id_bit, complement_bit, output ready);
endinterface

// Response channel: one beat per request beat
interface ows_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        write_bit;
	logic [63:0] rom_code;
	logic        last_device_found;

	modport source (output valid, status, write_bit, rom_code, last_device_found, input ready);
	modport sink   (input valid, status, write_bit, rom_code, last_device_found, output ready);
endinterface

// ===== design/onewire_rom_search.sv =====
// 1-Wire search-ROM engine.
// req carries one beat per event seen on the bus: restart of the enumeration,
// the result of a bus reset (presence bit), or the ID bit and its complement
// read in one search slot. For each req beat exactly one rsp beat is returned:
// a status code, the direction bit to write back (bit-pair beats only), the
// current 64-bit ROM image and the last-device flag.
// Latency: the rsp beat is valid in the cycle after the req beat is taken.
// Throughput: one beat per cycle while rsp.ready stays high. The whole state
// update for a beat is done in the accepting cycle between the state registers
// and the response register, so the next beat may follow straight away.
// Stall: the response register holds its beat while rsp.ready is low; req is
// still taken in a cycle where that beat leaves (rsp.ready high), otherwise
// req.ready drops until the receiver takes it.
// Reset (arst_n low): ROM image, discrepancy markers and CRC are cleared, the
// bit position goes to 1, no pass is active and no response is pending.
// After bit 64 of a pass the response reports found or CRC error; the CRC-8
// (reflected poly 0x8C) covers ROM bits 1..56 and is checked against bits
// 57..64.
module onewire_rom_search (
	input  logic          clk,
	input  logic          arst_n,
	ows_req_if.sink       req,
	ows_rsp_if.source     rsp
);

	localparam int unsigned PW = ows_pkg::POS_W;

	// Search state
	logic [63:0]    rom_q,      rom_d;
	logic [PW-1:0]  last_disc_q, last_disc_d;
	logic [PW-1:0]  last_zero_q, last_zero_d;
	logic [PW-1:0]  bit_pos_q,  bit_pos_d;
	logic           last_dev_q, last_dev_d;
	logic           pass_q,     pass_d;
	logic [7:0]     crc_q,      crc_d;

	// Response register
	logic           rsp_valid_q;
	ows_pkg::status_t status_q, status_d;
	logic           wbit_q,     wbit_d;
	logic [63:0]    rom_out_q;
	logic           last_dev_out_q;

	logic           accept;
	logic [5:0]     bit_idx;   // ROM bit n sits at index n-1
	logic           dir;
	logic           mix;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign bit_idx   = 6'(bit_pos_q - ows_pkg::FIRST_BIT);

	always_comb begin
		rom_d       = rom_q;
		last_disc_d = last_disc_q;
		last_zero_d = last_zero_q;
		bit_pos_d   = bit_pos_q;
		last_dev_d  = last_dev_q;
		pass_d      = pass_q;
		crc_d       = crc_q;
		status_d    = ows_pkg::ST_IGNORED;
		wbit_d      = 1'b0;
		dir         = 1'b0;
		mix         = 1'b0;

		case (req.kind)
			ows_pkg::KIND_RESTART: begin
				rom_d       = '0;
				last_disc_d = '0;
				last_zero_d = '0;
				bit_pos_d   = ows_pkg::FIRST_BIT;
				last_dev_d  = 1'b0;
				pass_d      = 1'b0;
				crc_d       = '0;
			end
			ows_pkg::KIND_BUS_RESET: begin
				if (last_dev_q) begin
					pass_d   = 1'b0;
					status_d = ows_pkg::ST_DONE;
				end else if (!req.presence) begin
					last_disc_d = '0;
					last_dev_d  = 1'b0;
					pass_d      = 1'b0;
					status_d    = ows_pkg::ST_NO_PRESENCE;
				end else begin
					pass_d      = 1'b1;
					bit_pos_d   = ows_pkg::FIRST_BIT;
					last_zero_d = '0;
					crc_d       = '0;
					status_d    = ows_pkg::ST_PASS_STARTED;
				end
			end
			ows_pkg::KIND_BIT_PAIR: begin
				if (pass_q && bit_pos_q >= ows_pkg::FIRST_BIT
						&& bit_pos_q < ows_pkg::END_POSITION) begin
					if (req.id_bit && req.complement_bit) begin
						// nobody answered the slot
						pass_d   = 1'b0;
						status_d = ows_pkg::ST_NO_RESPONSE;
					end else begin
						if (req.id_bit != req.complement_bit) begin
							dir = req.id_bit;
						end else begin
							// discrepancy: follow last path, take 1 at the old marker
							if (bit_pos_q < last_disc_q)
								dir = rom_q[bit_idx];
							else
								dir = (bit_pos_q == last_disc_q);
							if (!dir)
								last_zero_d = bit_pos_q;
						end
						rom_d[bit_idx] = dir;
						if (bit_pos_q <= ows_pkg::CRC_BITS) begin
							mix   = crc_q[0] ^ dir;
							crc_d = (crc_q >> 1) ^ (mix ? ows_pkg::CRC_POLY : 8'h00);
						end
						bit_pos_d = bit_pos_q + ows_pkg::FIRST_BIT;
						wbit_d    = dir;
						status_d  = ows_pkg::ST_BIT_CHOSEN;
						if (bit_pos_q == ows_pkg::LAST_BIT) begin
							last_disc_d = last_zero_d;
							if (last_zero_d == '0)
								last_dev_d = 1'b1;
							pass_d   = 1'b0;
							status_d = (crc_d == rom_d[63:56]) ? ows_pkg::ST_FOUND
											   : ows_pkg::ST_CRC_ERROR;
						end
					end
				end
			end
			default: begin
				status_d = ows_pkg::ST_IGNORED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_q       <= '0;
			last_disc_q <= '0;
			last_zero_q <= '0;
			bit_pos_q   <= ows_pkg::FIRST_BIT;
			last_dev_q  <= 1'b0;
			pass_q      <= 1'b0;
			crc_q       <= '0;
		end else if (accept) begin
			rom_q       <= rom_d;
			last_disc_q <= last_disc_d;
			last_zero_q <= last_zero_d;
			bit_pos_q   <= bit_pos_d;
			last_dev_q  <= last_dev_d;
			pass_q      <= pass_d;
			crc_q       <= crc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q       <= status_d;
			wbit_q         <= wbit_d;
			rom_out_q      <= rom_d;
			last_dev_out_q <= last_dev_d;
		end
	end

	assign rsp.valid             = rsp_valid_q;
	assign rsp.status            = status_q;
	assign rsp.write_bit         = wbit_q;
	assign rsp.rom_code          = rom_out_q;
	assign rsp.last_device_found = last_dev_out_q;

	// A beat taken always leaves a response waiting in the next cycle
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_q)
		else $error("response missing after accepted beat");

	// During a pass the bit position stays within the ROM
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pass_q |-> (bit_pos_q >= ows_pkg::FIRST_BIT && bit_pos_q <= ows_pkg::LAST_BIT))
		else $error("bit position out of range during pass");

	// The last-device flag only rises at the end of a completed pass
	a_last_dev: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(last_dev_q) |-> (bit_pos_q == ows_pkg::END_POSITION && !pass_q))
		else $error("last device flagged outside pass end");

	// A chosen bit advances the position by one
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && status_d == ows_pkg::ST_BIT_CHOSEN)
			|=> bit_pos_q == $past(bit_pos_q) + ows_pkg::FIRST_BIT)
		else $error("bit position did not advance");

endmodule
